>>> rtl/core/hdc_pkg.sv
// Shared types, constants and decode functions of the Hamming deframer and decoder.
package hdc_pkg;

    localparam int MaxCodeBits = 71;
    localparam int DataBits    = 64;
    localparam int SynBits     = 7;

    // Word formats selected by the code_mode register.
    localparam logic [1:0] MODE_12_8  = 2'd0;
    localparam logic [1:0] MODE_21_16 = 2'd1;
    localparam logic [1:0] MODE_38_32 = 2'd2;
    localparam logic [1:0] MODE_71_64 = 2'd3;

    localparam int Len0 = 12;
    localparam int Len1 = 21;
    localparam int Len2 = 38;
    localparam int Len3 = 71;

    // Register addresses (byte address bit 2 selects the register).
    localparam logic REG_CODE_MODE = 1'b0;

    // A full code word, position p held at bit p-1, positions past the word length zero.
    typedef struct packed {
        logic [1:0]             mode;
        logic [MaxCodeBits-1:0] bits;
    } t_word;

    typedef struct packed {
        logic  push;
        t_word word;
    } t_wq_wr;

    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       last;
    } t_oq_wr;

    function automatic logic [6:0] f_word_len(input logic [1:0] mode);
        logic [6:0] len;
        begin
            case (mode)
                MODE_12_8:  len = 7'(Len0);
                MODE_21_16: len = 7'(Len1);
                MODE_38_32: len = 7'(Len2);
                MODE_71_64: len = 7'(Len3);
                default:    len = 7'(Len0);
            endcase
            return len;
        end
    endfunction

    function automatic logic [2:0] f_bits_per_byte(input logic [1:0] mode);
        logic [2:0] per;
        begin
            case (mode)
                MODE_12_8:  per = 3'd6;
                MODE_21_16: per = 3'd7;
                MODE_38_32: per = 3'd2;
                MODE_71_64: per = 3'd1;
                default:    per = 3'd6;
            endcase
            return per;
        end
    endfunction

    function automatic logic [3:0] f_bytes_per_word(input logic [1:0] mode);
        logic [3:0] n;
        begin
            case (mode)
                MODE_12_8:  n = 4'd1;
                MODE_21_16: n = 4'd2;
                MODE_38_32: n = 4'd4;
                MODE_71_64: n = 4'd8;
                default:    n = 4'd1;
            endcase
            return n;
        end
    endfunction

    // The gather register shifts bits in at the bottom, so the first code bit of a
    // word of length L sits at index L-1. Reorder to position order, zero beyond L.
    function automatic logic [MaxCodeBits-1:0] f_normalize(input logic [MaxCodeBits-1:0] sh,
                                                           input logic [1:0] mode);
        logic [MaxCodeBits-1:0] w;
        begin
            w = '0;
            case (mode)
                MODE_12_8:  for (int p = 1; p <= Len0; p++) w[p-1] = sh[Len0-p];
                MODE_21_16: for (int p = 1; p <= Len1; p++) w[p-1] = sh[Len1-p];
                MODE_38_32: for (int p = 1; p <= Len2; p++) w[p-1] = sh[Len2-p];
                MODE_71_64: for (int p = 1; p <= Len3; p++) w[p-1] = sh[Len3-p];
                default:    w = '0;
            endcase
            return w;
        end
    endfunction

    // Even-parity checks over the power-of-two positions; each failing check adds its weight.
    function automatic logic [SynBits-1:0] f_syndrome(input logic [MaxCodeBits-1:0] w);
        logic [SynBits-1:0] s;
        begin
            s = '0;
            for (int i = 0; i < SynBits; i++) begin
                for (int j = 1; j <= MaxCodeBits; j++) begin
                    if (((j >> i) & 1) == 1) s[i] = s[i] ^ w[j-1];
                end
            end
            return s;
        end
    endfunction

    // Data bits are the positions that are not powers of two, first one at the MSB.
    function automatic logic [DataBits-1:0] f_extract(input logic [MaxCodeBits-1:0] w);
        logic [DataBits-1:0] d;
        int                  k;
        begin
            d = '0;
            k = 0;
            for (int j = 1; j <= MaxCodeBits; j++) begin
                if ((j & (j - 1)) != 0) begin
                    d[DataBits-1-k] = w[j-1];
                    k++;
                end
            end
            return d;
        end
    endfunction

endpackage

>>> rtl/core/hdc_front.sv
// Front end: gathers code bits from the byte stream and hands full words to the word queue.
module hdc_front import hdc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_mode,
    input  logic       i_cfg_wr,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output t_wq_wr     o_wq_wr
);

    logic [MaxCodeBits-1:0] r_shift, n_shift;
    logic [6:0]             r_cnt, n_cnt;
    logic [6:0]             sum;
    logic                   done;

    always_comb begin
        case (i_mode)
            MODE_12_8:  n_shift = {r_shift[MaxCodeBits-7:0], i_byte[5:0]};
            MODE_21_16: n_shift = {r_shift[MaxCodeBits-8:0], i_byte[6:0]};
            MODE_38_32: n_shift = {r_shift[MaxCodeBits-3:0], i_byte[1:0]};
            MODE_71_64: n_shift = {r_shift[MaxCodeBits-2:0], i_byte[0]};
            default:    n_shift = r_shift;
        endcase
        sum   = r_cnt + 7'(f_bits_per_byte(i_mode));
        done  = (sum >= f_word_len(i_mode));
        n_cnt = done ? 7'd0 : sum;
    end

    assign o_wq_wr.push      = i_accept && done;
    assign o_wq_wr.word.mode = i_mode;
    assign o_wq_wr.word.bits = f_normalize(n_shift, i_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_shift <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_cnt <= '0;
            end else if (i_accept) begin
                r_cnt <= n_cnt;
            end
            if (i_accept) begin
                r_shift <= n_shift;
            end
        end
    end

endmodule

>>> rtl/core/hdc_word_fifo.sv
// Two-entry queue of full code words between the front and back ends.
module hdc_word_fifo import hdc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_wq_wr i_wr,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_word  o_word
);

    t_word      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_word  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_wr.push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_wr.push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= i_wr.word;
        end
    end

endmodule

>>> rtl/core/hdc_back.sv
// Back end: syndrome stage, correction and extraction, then byte serializer.
module hdc_back import hdc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wq_empty,
    input  t_word  i_word,
    output logic   o_wq_pop,
    input  logic   i_oq_full,
    output t_oq_wr o_oq_wr
);

    logic                   r_a_valid;
    t_word                  r_a_word;
    logic [SynBits-1:0]     r_a_syn;
    logic [DataBits-1:0]    r_data;
    logic [3:0]             r_left;

    logic                   push_ok;
    logic                   b_take;
    logic                   a_take;
    logic [MaxCodeBits-1:0] flip;
    logic                   fix;

    assign push_ok  = (r_left != 4'd0) && !i_oq_full;
    assign b_take   = r_a_valid && ((r_left == 4'd0) || ((r_left == 4'd1) && push_ok));
    assign a_take   = !i_wq_empty && (!r_a_valid || b_take);
    assign o_wq_pop = a_take;

    // A syndrome that names a position past the word is left uncorrected.
    assign fix = (r_a_syn != '0) && (r_a_syn <= f_word_len(r_a_word.mode));

    always_comb begin
        flip = '0;
        for (int j = 1; j <= MaxCodeBits; j++) begin
            flip[j-1] = fix && (r_a_syn == SynBits'(j));
        end
    end

    assign o_oq_wr.push = push_ok;
    assign o_oq_wr.data = r_data[DataBits-1 -: 8];
    assign o_oq_wr.last = (r_left == 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_left    <= '0;
        end else begin
            if (a_take) begin
                r_a_valid <= 1'b1;
            end else if (b_take) begin
                r_a_valid <= 1'b0;
            end
            if (b_take) begin
                r_left <= f_bytes_per_word(r_a_word.mode);
            end else if (push_ok) begin
                r_left <= r_left - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_take) begin
            r_a_word <= i_word;
            r_a_syn  <= f_syndrome(i_word.bits);
        end
        if (b_take) begin
            r_data <= f_extract(r_a_word.bits ^ flip);
        end else if (push_ok) begin
            r_data <= {r_data[DataBits-9:0], 8'd0};
        end
    end

endmodule

>>> rtl/core/hdc_out_fifo.sv
// Four-entry result queue that drives the output ports.
module hdc_out_fifo import hdc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_oq_wr     i_wr,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_data,
    output logic       o_last
);

    logic [8:0] r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic       pop_ok;

    assign o_full  = (r_count == 3'd4);
    assign o_empty = (r_count == 3'd0);
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr][8:1];
    assign o_last  = r_mem[r_rd_ptr][0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr.push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            case ({i_wr.push, pop_ok})
                2'b10:   r_count <= r_count + 3'd1;
                2'b01:   r_count <= r_count - 3'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= {i_wr.data, i_wr.last};
        end
    end

endmodule

>>> rtl/core/hamming_deframe_correct_decoder.sv
// Top level of the Hamming single-error-correcting deframer and decoder.
//
// The block takes one coded byte per clock cycle and, according to code_mode,
// gathers its low 6, 7, 2 or 1 bits (most significant first) into code words of
// 12, 21, 38 or 71 bits. Each full word runs the even-parity checks over the
// power-of-two positions; a nonzero syndrome that names a position inside the
// word flips that bit, and the 8, 16, 32 or 64 data bits leave as 1, 2, 4 or 8
// bytes, the final byte of each word marked by o_last_in_word. Input transfers
// are taken every cycle as long as full is low; full rises only when the
// two-entry word queue between the gathering front end and the decoding back
// end holds two words. The back end emits one byte per cycle into a four-entry
// result queue while that queue is not full, and this serializer sets the
// sustained word rate. The first byte of a word passes the word queue, the
// syndrome register, the data register and the result queue before it can be
// popped. Writing code_mode discards any partially gathered word; write it only
// while the block is idle. code_mode sits at byte address 0 of the register
// port, reads back in bits 1:0, and pready is always high.
module hamming_deframe_correct_decoder import hdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_coded_byte,
    // Result queue side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_data_byte,
    output logic        o_last_in_word,
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] r_code_mode;
    logic       cfg_wr;
    logic       in_accept;
    t_wq_wr     wq_wr;
    logic       wq_full;
    logic       wq_empty;
    logic       wq_pop;
    t_word      wq_word;
    t_oq_wr     oq_wr;
    logic       oq_full;

    // Register access: bit 2 of the byte address selects the register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CODE_MODE);
    assign prdata = (paddr[2] == REG_CODE_MODE) ? {30'd0, r_code_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_mode <= MODE_12_8;
        end else if (cfg_wr) begin
            r_code_mode <= pwdata[1:0];
        end
    end

    // The front end is held off only while the word queue is full.
    assign full      = wq_full;
    assign in_accept = push && !full;

    hdc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_code_mode),
        .i_cfg_wr (cfg_wr),
        .i_accept (in_accept),
        .i_byte   (i_coded_byte),
        .o_wq_wr  (wq_wr)
    );

    hdc_word_fifo u_word_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wq_wr),
        .o_full  (wq_full),
        .i_pop   (wq_pop),
        .o_empty (wq_empty),
        .o_word  (wq_word)
    );

    hdc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wq_empty (wq_empty),
        .i_word     (wq_word),
        .o_wq_pop   (wq_pop),
        .i_oq_full  (oq_full),
        .o_oq_wr    (oq_wr)
    );

    hdc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (oq_wr),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_data_byte),
        .o_last  (o_last_in_word)
    );

    // A completed word must never be pushed into a full word queue.
    a_wq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wq_wr.push |-> !wq_full)
        else $error("word queue written while full");

    // The serializer must never push a byte into a full result queue.
    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_wr.push |-> !oq_full)
        else $error("result queue written while full");

    // The back end must not pop an empty word queue.
    a_wq_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wq_pop |-> !wq_empty)
        else $error("word queue popped while empty");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the Hamming deframer and single-error-correcting decoder.
`timescale 1ns / 100ps

module tb;
    import hdc_pkg::*;

    // One transfer on the result side: a decoded data byte and its end-of-word flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_data_out;

    // One row of the directed stimulus. A row either writes code_mode (cfg set) or offers
    // one coded byte. When n_typed is nonzero, the row completes a word whose decoded bytes
    // are written out by hand in typed (first byte in the upper half), and those bytes are
    // checked instead of the predictor output.
    typedef struct packed {
        logic        cfg;
        logic [7:0]  val;
        logic [1:0]  n_typed;
        logic [15:0] typed;
    } t_stim_row;

    localparam int            HalfPeriodNs = 4;
    localparam int            TimeoutNs    = 400_000;
    localparam int            DrainCycles  = 16;
    localparam int            HoldCycles   = 150;
    localparam int            TailCycles   = 24;
    localparam logic [2:0]    CodeModeAddr = {REG_CODE_MODE, 2'b00};
    localparam int            NumDirRows   = 25;

    // Directed part. In the default 12/8 mode every pair of bytes is one word, and each
    // word below decodes to a byte that can be read off by hand: a clean all-zero word, a
    // clean all-ones data word with the unused upper input bits set, an error in a parity
    // position, an error in the last data position, and a double error whose syndrome
    // points past the end of the word so nothing is flipped. Each mode is then entered
    // with part of a word still gathered, so that the partial word must be dropped.
    localparam t_stim_row DirRows [NumDirRows] = '{
        '{1'b0, 8'h00, 2'd0, 16'h0000},
        '{1'b0, 8'h00, 2'd1, 16'h0000},
        '{1'b0, 8'hFB, 2'd0, 16'h0000},
        '{1'b0, 8'hEF, 2'd1, 16'hFF00},
        '{1'b0, 8'h20, 2'd0, 16'h0000},
        '{1'b0, 8'h00, 2'd1, 16'h0000},
        '{1'b0, 8'h3B, 2'd0, 16'h0000},
        '{1'b0, 8'h2E, 2'd1, 16'hFF00},
        '{1'b0, 8'h00, 2'd0, 16'h0000},
        '{1'b0, 8'h30, 2'd1, 16'h1000},
        '{1'b0, 8'hFF, 2'd0, 16'h0000},
        '{1'b0, 8'hFF, 2'd0, 16'h0000},
        '{1'b0, 8'h15, 2'd0, 16'h0000},
        '{1'b1, 8'h01, 2'd0, 16'h0000},
        '{1'b0, 8'h00, 2'd0, 16'h0000},
        '{1'b0, 8'h00, 2'd0, 16'h0000},
        '{1'b0, 8'h00, 2'd2, 16'h0000},
        '{1'b0, 8'hFF, 2'd0, 16'h0000},
        '{1'b0, 8'hFF, 2'd0, 16'h0000},
        '{1'b0, 8'hFF, 2'd0, 16'h0000},
        '{1'b0, 8'h80, 2'd0, 16'h0000},
        '{1'b1, 8'h02, 2'd0, 16'h0000},
        '{1'b0, 8'h03, 2'd0, 16'h0000},
        '{1'b1, 8'h03, 2'd0, 16'h0000},
        '{1'b0, 8'h01, 2'd0, 16'h0000}
    };

    // Clock, reset and every input of the block start at known values.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic [7:0]  i_coded_byte = 8'h00;
    logic        empty;
    logic        pop          = 1'b0;
    logic [7:0]  o_data_byte;
    logic        o_last_in_word;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = 3'd0;
    logic [31:0] pwdata       = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // The hand-written expectation travels with the byte it belongs to, so that the
    // monitor sees both at the same clock edge.
    logic [1:0]  tag_n        = 2'd0;
    logic [15:0] tag_bytes    = 16'h0000;

    // Idling controls, set by the main sequence and read by the sender and the receiver.
    int          gap_pct      = 0;
    int          stall_pct    = 0;
    bit          hold_req     = 1'b0;

    int          errors       = 0;

    // Predictor state: the selected format, the code bits gathered so far (one-based
    // positions) and how many of them belong to the current word.
    logic [1:0]             pred_mode  = MODE_12_8;
    logic [MaxCodeBits:1]   pred_bits  = '0;
    logic [6:0]             pred_count = '0;
    t_data_out              pending [$];

    hamming_deframe_correct_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_coded_byte   (i_coded_byte),
        .empty          (empty),
        .pop            (pop),
        .o_data_byte    (o_data_byte),
        .o_last_in_word (o_last_in_word),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #HalfPeriodNs i_clk = 1'b1;
        #HalfPeriodNs i_clk = 1'b0;
    end

    // Code word length and code bits taken from each byte, per format.
    function automatic int code_len(input logic [1:0] m);
        case (m)
            MODE_12_8:  return Len0;
            MODE_21_16: return Len1;
            MODE_38_32: return Len2;
            default:    return Len3;
        endcase
    endfunction

    function automatic int bits_each(input logic [1:0] m);
        case (m)
            MODE_12_8:  return 6;
            MODE_21_16: return 7;
            MODE_38_32: return 2;
            default:    return 1;
        endcase
    endfunction

    // Builds a clean code word: the data bits, first one from data[63], fill the
    // positions that are not powers of two, and each power-of-two position gets the
    // even parity of the positions that have its bit set.
    function automatic logic [MaxCodeBits:1] encode_word(input int len, input logic [63:0] data);
        logic [MaxCodeBits:1] w;
        int                   k;
        w = '0;
        k = 63;
        for (int j = 1; j <= len; j++) begin
            if ((j & (j - 1)) != 0) begin
                w[j] = data[k];
                k--;
            end
        end
        for (int p = 1; p <= len; p = p * 2) begin
            for (int j = p + 1; j <= len; j++) begin
                if ((j & p) != 0) w[p] = w[p] ^ w[j];
            end
        end
        return w;
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 100) $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Takes one accepted coded byte into the predictor. When it completes a word, the
    // parity checks are folded into a syndrome (the XOR of the positions that hold a one
    // gives exactly the sum of the failing checks), an in-range syndrome flips its bit,
    // and the data bits go out as bytes with the end-of-word flag on the final one.
    task automatic absorb_coded_byte(input logic [7:0] b, input logic [1:0] n_typed,
                                     input logic [15:0] typed);
        int         len;
        int         per;
        int         nacc;
        logic [6:0] syn;
        logic [7:0] acc;
        logic [7:0] bytes_out [$];
        len = code_len(pred_mode);
        per = bits_each(pred_mode);
        for (int k = per - 1; k >= 0; k--) begin
            if (pred_count < len) begin
                pred_count++;
                pred_bits[pred_count] = b[k];
            end
        end
        if (pred_count < len) return;
        pred_count = '0;
        syn = '0;
        for (int j = 1; j <= len; j++) begin
            if (pred_bits[j]) syn = syn ^ 7'(j);
        end
        if (syn != 0 && syn <= len) pred_bits[syn] = ~pred_bits[syn];
        acc  = '0;
        nacc = 0;
        for (int j = 1; j <= len; j++) begin
            if ((j & (j - 1)) != 0) begin
                acc = {acc[6:0], pred_bits[j]};
                nacc++;
                if (nacc == 8) begin
                    bytes_out.push_back(acc);
                    nacc = 0;
                end
            end
        end
        // A directed row with its answer written out replaces the computed bytes.
        if (n_typed != 0) begin
            bytes_out.delete();
            bytes_out.push_back(typed[15:8]);
            if (n_typed == 2) bytes_out.push_back(typed[7:0]);
        end
        foreach (bytes_out[i]) pending.push_back({bytes_out[i], 1'(i == bytes_out.size() - 1)});
    endtask

    // Monitor. Everything is sampled at the rising edge, before the block or the
    // testbench updates anything, so each handshake is seen as it was when the edge came.
    // A register write is applied first, then an input transfer, then a result transfer.
    always @(posedge i_clk) begin
        t_data_out want;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready && paddr == CodeModeAddr) begin
                pred_mode  = pwdata[1:0];
                pred_count = '0;
            end
            if (push && !full) absorb_coded_byte(i_coded_byte, tag_n, tag_bytes);
            if (pop && !empty) begin
                if (pending.size() == 0) begin
                    note_error($sformatf("unexpected result transfer: data %02h last %0b",
                                         o_data_byte, o_last_in_word));
                end else begin
                    want = pending.pop_front();
                    if (o_data_byte !== want.data)
                        note_error($sformatf("data_byte %02h, expected %02h",
                                             o_data_byte, want.data));
                    if (o_last_in_word !== want.last)
                        note_error($sformatf("last_in_word %0b, expected %0b (data %02h)",
                                             o_last_in_word, want.last, want.data));
                end
            end
        end
    end

    // Offers one coded byte, after a random number of idle cycles, and returns at the
    // edge where the transfer takes place.
    task automatic send_byte(input logic [7:0] b, input logic [1:0] n_typed,
                             input logic [15:0] typed);
        while ($urandom_range(99) < gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_coded_byte <= b;
        tag_n        <= n_typed;
        tag_bytes    <= typed;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // Reads code_mode back over the register port and compares bits 1:0.
    task automatic check_code_mode(input logic [1:0] m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CodeModeAddr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[1:0] !== m) note_error($sformatf("code_mode reads %0d, expected %0d",
                                                    prdata[1:0], m));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes code_mode once the block is idle: the input side stops, every pending result
    // has to come out, and then DrainCycles more cycles pass so no word is still in flight.
    task automatic write_code_mode(input logic [1:0] m);
        push <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CodeModeAddr;
        pwdata  <= {30'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        check_code_mode(m);
    endtask

    // Sends nwords code words in format m. Most words are proper code words with random
    // data carrying no error, one error or two errors; a few are pure noise. The unused
    // upper bits of each byte are random. Half the time a random part of one more word,
    // possibly empty, follows, which the next register write has to drop.
    task automatic send_words(input logic [1:0] m, input int nwords);
        int                   len;
        int                   per;
        int                   kind;
        int                   nbytes;
        logic [MaxCodeBits:1] w;
        logic [7:0]           b;
        len    = code_len(m);
        per    = bits_each(m);
        nbytes = len / per;
        for (int n = 0; n < nwords; n++) begin
            w    = encode_word(len, {$urandom, $urandom});
            kind = $urandom_range(9);
            if (kind == 0) begin
                w = MaxCodeBits'({$urandom, $urandom, $urandom});
            end else if (kind <= 2) begin
                w[$urandom_range(len, 1)] ^= 1'b1;
                w[$urandom_range(len, 1)] ^= 1'b1;
            end else if (kind <= 7) begin
                w[$urandom_range(len, 1)] ^= 1'b1;
            end
            for (int i = 0; i < nbytes; i++) begin
                b = 8'($urandom);
                for (int k = 0; k < per; k++) b[per - 1 - k] = w[i * per + k + 1];
                send_byte(b, 2'd0, 16'h0000);
            end
        end
        if ($urandom_range(1) == 1) begin
            for (int i = $urandom_range(nbytes - 1); i > 0; i--)
                send_byte(8'($urandom), 2'd0, 16'h0000);
        end
    endtask

    // Receiver. It pops at random according to stall_pct; once, on request, it holds off
    // for a long stretch so that both internal queues fill and the input side stalls.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                hold_req = 1'b0;
            end
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Main sequence: reset, directed rows, then random phases with different idling.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_code_mode(MODE_12_8);

        for (int i = 0; i < NumDirRows; i++) begin
            if (DirRows[i].cfg) write_code_mode(DirRows[i].val[1:0]);
            else send_byte(DirRows[i].val, DirRows[i].n_typed, DirRows[i].typed);
        end

        // Back-to-back transfers while the receiver holds off.
        write_code_mode(MODE_12_8);
        hold_req = 1'b1;
        send_words(MODE_12_8, 12);

        gap_pct   = 47;
        stall_pct = 0;
        write_code_mode(MODE_21_16);
        send_words(MODE_21_16, 4);

        gap_pct   = 0;
        stall_pct = 47;
        write_code_mode(MODE_38_32);
        send_words(MODE_38_32, 2);

        gap_pct   = 32;
        stall_pct = 32;
        write_code_mode(MODE_71_64);
        send_words(MODE_71_64, 1);
        write_code_mode(MODE_12_8);
        send_words(MODE_12_8, 2);
        push <= 1'b0;

        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #TimeoutNs;
        $display("ERROR: timeout with %0d results still pending", pending.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
